/* rtl/mpfsr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mpfsr_pkg
// Shared types, codes and float format helpers for the multi-peer sum reducer.
// ----------------------------------------------------------------------------
package mpfsr_pkg;

    localparam logic [1:0] FMT_FP32 = 2'd0;
    localparam logic [1:0] FMT_FP16 = 2'd1;
    localparam logic [1:0] FMT_BF16 = 2'd2;

    localparam logic [31:0] QNAN32 = 32'h7FC0_0000;
    localparam logic [31:0] QNAN16 = 32'h0000_7E00;
    localparam logic [31:0] QNANBF = 32'h0000_7FC0;

    typedef enum logic [1:0] {
        REG_PEER_COUNT     = 2'd0,
        REG_FIRST_PEER     = 2'd1,
        REG_ELEMENT_FORMAT = 2'd2
    } mpfsr_reg_t;

    // travels with every transaction through the chain
    typedef struct packed {
        logic [1:0] fmt;
        logic       tail;
        logic [3:0] cnt;
    } mpfsr_ctrl_t;

    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] lz;
        lz = 5'd27;
        for (int i = 0; i < 27; i++) begin
            if (v[i]) begin
                lz = 5'(26 - i);
            end
        end
        return lz;
    endfunction

    // element bits to fp32 bits, exact
    function automatic logic [31:0] fp_widen(input logic [1:0] fmt, input logic [31:0] v);
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [23:0] sm;
        logic [31:0] r;
        int          p;
        ex  = v[14:10];
        man = v[9:0];
        p   = 0;
        sm  = '0;
        r   = v;
        case (fmt)
            FMT_FP16: begin
                if (ex == 5'd0) begin
                    for (int i = 0; i < 10; i++) begin
                        if (man[i]) begin
                            p = i;
                        end
                    end
                    sm = 24'(man) << (23 - p);
                    if (man == 10'd0) begin
                        r = {v[15], 31'd0};
                    end else begin
                        r = {v[15], 8'(p + 103), sm[22:0]};
                    end
                end else if (ex == 5'd31) begin
                    r = {v[15], 8'hFF, man, 13'd0};
                end else begin
                    r = {v[15], 8'({3'd0, ex} + 8'd112), man, 13'd0};
                end
            end
            FMT_BF16: r = {v[15:0], 16'd0};
            default:  r = v;
        endcase
        return r;
    endfunction

    // fp32 bits to element bits, round to nearest even, NaN made canonical
    function automatic logic [31:0] fp_narrow(input logic [1:0] fmt, input logic [31:0] x);
        logic        sgn;
        logic        nan;
        logic [7:0]  ex;
        logic [23:0] man;
        logic [23:0] h;
        logic [23:0] rem;
        logic [23:0] half;
        logic [32:0] bs;
        logic [31:0] r;
        int          e;
        int          sh;
        sgn  = x[31];
        ex   = x[30:23];
        man  = {1'b0, x[22:0]};
        nan  = (ex == 8'hFF) && (x[22:0] != 23'd0);
        e    = int'(ex) - 112;
        h    = '0;
        rem  = '0;
        half = '0;
        sh   = 0;
        bs   = 33'(x) + 33'h7FFF + 33'(x[16]);
        r    = x;
        case (fmt)
            FMT_FP16: begin
                if (nan) begin
                    r = QNAN16;
                end else if (ex == 8'hFF || e >= 31) begin
                    r = {16'd0, sgn, 15'h7C00};
                end else if (e <= 0) begin
                    if (e < -10) begin
                        r = {16'd0, sgn, 15'd0};
                    end else begin
                        man[23] = 1'b1;
                        sh   = 14 - e;
                        h    = man >> sh;
                        rem  = man & ((24'd1 << sh) - 24'd1);
                        half = 24'd1 << (sh - 1);
                        if (rem > half || (rem == half && h[0])) begin
                            h = h + 24'd1;
                        end
                        r = {16'd0, sgn, h[14:0]};
                    end
                end else begin
                    h   = 24'({e[4:0], man[22:13]});
                    rem = 24'(man[12:0]);
                    if (rem > 24'h1000 || (rem == 24'h1000 && h[0])) begin
                        h = h + 24'd1;
                    end
                    r = {16'd0, sgn, h[14:0]};
                end
            end
            FMT_BF16: r = nan ? QNANBF : {16'd0, bs[31:16]};
            default:  r = nan ? QNAN32 : x;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/mpfsr_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mpfsr_cell
// One link of the reduction chain: adds operand K to the running sum in fp32
// (align/add, normalise/round, requantise), or passes it on if K is unused.
// ----------------------------------------------------------------------------
module mpfsr_cell
    import mpfsr_pkg::*;
#(
    parameter int MAX_PEERS = 8,
    parameter int K         = 1
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [31:0]             in_acc,
    input  wire logic [MAX_PEERS*32-1:0] in_ops,
    input  wire mpfsr_ctrl_t             in_ctrl,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [31:0]                  out_acc,
    output logic [MAX_PEERS*32-1:0]      out_ops,
    output mpfsr_ctrl_t                  out_ctrl
);

    localparam int OW = MAX_PEERS * 32;

    logic en_a, en_b, en_c;
    logic va_reg, vb_reg, vc_reg;

    // stage A registers
    logic              a_sign_reg, a_nan_reg, a_inf_reg, a_infs_reg, a_zs_reg, a_byp_reg;
    logic [7:0]        a_exp_reg;
    logic [27:0]       a_sum_reg;
    logic [31:0]       a_acc_reg;
    logic [OW-1:0]     a_ops_reg;
    mpfsr_ctrl_t       a_ctrl_reg;
    // stage B registers
    logic [31:0]       b_res_reg;
    logic              b_byp_reg;
    logic [OW-1:0]     b_ops_reg;
    mpfsr_ctrl_t       b_ctrl_reg;
    // stage C registers
    logic [31:0]       c_acc_reg;
    logic [OW-1:0]     c_ops_reg;
    mpfsr_ctrl_t       c_ctrl_reg;

    assign en_c     = !vc_reg || out_ready;
    assign en_b     = !vb_reg || en_c;
    assign en_a     = !va_reg || en_b;
    assign in_ready = en_a;

    // ---- stage A: compare, align, add ----
    logic [31:0] op_b, big, sml;
    logic        a_is_nan, b_is_nan, a_is_inf, b_is_inf, swap;
    logic [7:0]  eb, es, d;
    logic [23:0] mb, ms;
    logic [26:0] ext, al;
    logic        st;
    logic [27:0] sum_a;

    always_comb begin
        op_b     = in_ops[K*32 +: 32];
        a_is_nan = (in_acc[30:23] == 8'hFF) && (in_acc[22:0] != 23'd0);
        b_is_nan = (op_b[30:23] == 8'hFF) && (op_b[22:0] != 23'd0);
        a_is_inf = (in_acc[30:23] == 8'hFF) && (in_acc[22:0] == 23'd0);
        b_is_inf = (op_b[30:23] == 8'hFF) && (op_b[22:0] == 23'd0);
        swap     = op_b[30:0] > in_acc[30:0];
        big      = swap ? op_b : in_acc;
        sml      = swap ? in_acc : op_b;
        eb       = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es       = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d        = eb - es;
        mb       = {big[30:23] != 8'd0, big[22:0]};
        ms       = {sml[30:23] != 8'd0, sml[22:0]};
        ext      = {ms, 3'd0};
        if (d >= 8'd27) begin
            al = '0;
            st = |ms;
        end else begin
            al = ext >> d;
            st = |(ext & ((27'd1 << d) - 27'd1));
        end
        al[0] = al[0] | st;
        if (big[31] ^ sml[31]) begin
            sum_a = {1'b0, mb, 3'd0} - {1'b0, al};
        end else begin
            sum_a = {1'b0, mb, 3'd0} + {1'b0, al};
        end
    end

    // ---- stage B: normalise and round ----
    logic [4:0]  lz;
    logic [7:0]  em1, sh;
    logic [26:0] m;
    logic [9:0]  en_exp, ef;
    logic        up;
    logic [24:0] mr;
    logic [22:0] frac;
    logic [31:0] res_b;

    always_comb begin
        lz  = lzc27(a_sum_reg[26:0]);
        em1 = a_exp_reg - 8'd1;
        sh  = ({3'd0, lz} > em1) ? em1 : {3'd0, lz};
        if (a_sum_reg[27]) begin
            m      = {a_sum_reg[27:2], a_sum_reg[1] | a_sum_reg[0]};
            en_exp = {2'd0, a_exp_reg} + 10'd1;
        end else begin
            m      = a_sum_reg[26:0] << sh;
            en_exp = {2'd0, a_exp_reg} - {2'd0, sh};
        end
        up = m[2] & (m[1] | m[0] | m[3]);
        mr = {1'b0, m[26:3]} + 25'(up);
        if (mr[24]) begin
            ef   = en_exp + 10'd1;
            frac = '0;
        end else begin
            ef   = mr[23] ? en_exp : 10'd0;
            frac = mr[22:0];
        end
        if (a_byp_reg) begin
            res_b = a_acc_reg;
        end else if (a_nan_reg) begin
            res_b = QNAN32;
        end else if (a_inf_reg) begin
            res_b = {a_infs_reg, 8'hFF, 23'd0};
        end else if (a_sum_reg == 28'd0) begin
            res_b = {a_zs_reg, 31'd0};
        end else if (ef >= 10'd255) begin
            res_b = {a_sign_reg, 8'hFF, 23'd0};
        end else begin
            res_b = {a_sign_reg, ef[7:0], frac};
        end
    end

    // ---- stage C: outside tail mode, round back to the element format after each add ----
    logic [31:0] acc_c;

    always_comb begin
        if (!b_ctrl_reg.tail && !b_byp_reg) begin
            acc_c = fp_widen(b_ctrl_reg.fmt, fp_narrow(b_ctrl_reg.fmt, b_res_reg));
        end else begin
            acc_c = b_res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            if (en_a) va_reg <= in_valid;
            if (en_b) vb_reg <= va_reg;
            if (en_c) vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            a_sign_reg <= big[31];
            a_exp_reg  <= eb;
            a_sum_reg  <= sum_a;
            a_nan_reg  <= a_is_nan || b_is_nan
                          || (a_is_inf && b_is_inf && (in_acc[31] ^ op_b[31]));
            a_inf_reg  <= a_is_inf || b_is_inf;
            a_infs_reg <= a_is_inf ? in_acc[31] : op_b[31];
            a_zs_reg   <= in_acc[31] & op_b[31];
            a_byp_reg  <= !(in_ctrl.cnt > 4'(K));
            a_acc_reg  <= in_acc;
            a_ops_reg  <= in_ops;
            a_ctrl_reg <= in_ctrl;
        end
        if (en_b) begin
            b_res_reg  <= res_b;
            b_byp_reg  <= a_byp_reg;
            b_ops_reg  <= a_ops_reg;
            b_ctrl_reg <= a_ctrl_reg;
        end
        if (en_c) begin
            c_acc_reg  <= acc_c;
            c_ops_reg  <= b_ops_reg;
            c_ctrl_reg <= b_ctrl_reg;
        end
    end

    assign out_valid = vc_reg;
    assign out_acc   = c_acc_reg;
    assign out_ops   = c_ops_reg;
    assign out_ctrl  = c_ctrl_reg;

endmodule
`default_nettype wire

/* rtl/multi_peer_float_sum_reduce_unit.sv */
`default_nettype none
// The result passes through the input register, a chain of MAX_PEERS-1 adder
// cells of three stages each, and the output register. Throughput: one
// transaction per cycle while the output is not stalled.
// Each stage holds a transaction while downstream stalls; bubbles collapse.
// Reset (aresetn low, synchronous) empties the pipeline and sets
// peer_count 2, first_peer 0, element_format fp32.
// ----------------------------------------------------------------------------
// multi_peer_float_sum_reduce_unit
// Sums the values of up to MAX_PEERS peers per element in a rotated order.
// ----------------------------------------------------------------------------
module multi_peer_float_sum_reduce_unit
    import mpfsr_pkg::*;
#(
    parameter int MAX_PEERS = 8
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // peer_value_0 .. peer_value_N, 32 bits each from bit 0 up
    input  wire logic [MAX_PEERS*32-1:0] s_tdata,
    // tail_mode
    input  wire logic [0:0]              s_tuser,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // sum_value
    output logic [31:0]                  m_tdata,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [3:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int OW = MAX_PEERS * 32;
    localparam int IW = (MAX_PEERS > 2) ? $clog2(MAX_PEERS) : 1;

    logic [3:0] cnt_reg;
    logic [2:0] first_reg;
    logic [1:0] fmt_reg;
    mpfsr_reg_t widx;

    assign pready = 1'b1;
    assign widx   = mpfsr_reg_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= 4'd2;
            first_reg <= 3'd0;
            fmt_reg   <= FMT_FP32;
        end else if (psel && penable && pwrite && pready) begin
            case (widx)
                REG_PEER_COUNT:     cnt_reg   <= pwdata[3:0];
                REG_FIRST_PEER:     first_reg <= pwdata[2:0];
                REG_ELEMENT_FORMAT: fmt_reg   <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (widx)
            REG_PEER_COUNT:     prdata = {28'd0, cnt_reg};
            REG_FIRST_PEER:     prdata = {29'd0, first_reg};
            REG_ELEMENT_FORMAT: prdata = {30'd0, fmt_reg};
            default:            prdata = '0;
        endcase
    end

    // effective count, start peer and format
    logic [3:0]  n_eff;
    logic [3:0]  start;
    logic [1:0]  fmt_eff;
    logic [4:0]  idx;
    logic [OW-1:0] ops_in;

    always_comb begin
        if (cnt_reg < 4'd2) begin
            n_eff = 4'd2;
        end else if (cnt_reg > 4'(MAX_PEERS)) begin
            n_eff = 4'(MAX_PEERS);
        end else begin
            n_eff = cnt_reg;
        end
        fmt_eff = (fmt_reg == 2'd3) ? FMT_FP32 : fmt_reg;
        start   = {1'b0, first_reg};
        for (int i = 0; i < 3; i++) begin
            if (start >= n_eff) begin
                start = start - n_eff;
            end
        end
        ops_in = '0;
        for (int k = 0; k < MAX_PEERS; k++) begin
            idx = {1'b0, start} + 5'(k);
            if (idx >= {1'b0, n_eff}) begin
                idx = idx - {1'b0, n_eff};
            end
            ops_in[k*32 +: 32] = fp_widen(fmt_eff, s_tdata[idx[IW-1:0]*32 +: 32]);
        end
    end

    // chain links: index 0 is the input register, index K the output of cell K
    logic              lv    [MAX_PEERS];
    logic              lr    [MAX_PEERS];
    logic [31:0]       lacc  [MAX_PEERS];
    logic [OW-1:0]     lops  [MAX_PEERS];
    mpfsr_ctrl_t       lctrl [MAX_PEERS];

    logic          vi_reg;
    logic [OW-1:0] iops_reg;
    mpfsr_ctrl_t   ictrl_reg;
    logic          en_i;

    assign en_i     = !vi_reg || lr[0];
    assign s_tready = en_i;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vi_reg <= 1'b0;
        end else if (en_i) begin
            vi_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_i) begin
            iops_reg  <= ops_in;
            ictrl_reg <= '{fmt: fmt_eff, tail: s_tuser[0], cnt: n_eff};
        end
    end

    assign lv[0]    = vi_reg;
    assign lacc[0]  = iops_reg[31:0];
    assign lops[0]  = iops_reg;
    assign lctrl[0] = ictrl_reg;

    for (genvar g = 1; g < MAX_PEERS; g++) begin : g_cell
        mpfsr_cell #(
            .MAX_PEERS (MAX_PEERS),
            .K         (g)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (lv[g-1]),
            .in_ready  (lr[g-1]),
            .in_acc    (lacc[g-1]),
            .in_ops    (lops[g-1]),
            .in_ctrl   (lctrl[g-1]),
            .out_valid (lv[g]),
            .out_ready (lr[g]),
            .out_acc   (lacc[g]),
            .out_ops   (lops[g]),
            .out_ctrl  (lctrl[g])
        );
    end

    // output register with final rounding to the element format
    logic        vo_reg;
    logic [31:0] odata_reg;
    logic        en_o;

    assign en_o            = !vo_reg || m_tready;
    assign lr[MAX_PEERS-1] = en_o;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (en_o) begin
            vo_reg <= lv[MAX_PEERS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en_o) begin
            odata_reg <= fp_narrow(lctrl[MAX_PEERS-1].fmt, lacc[MAX_PEERS-1]);
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = odata_reg;

endmodule
`default_nettype wire

/* rtl/mpfsr_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mpfsr_checker
// Port-level checks on the sum reducer, bound to the top level.
// ----------------------------------------------------------------------------
module mpfsr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        pready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // nothing comes out straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // any fp32 NaN leaving the block is the canonical quiet NaN
    a_nan_canon: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[30:23] == 8'hFF && m_tdata[22:0] != 23'd0
        |-> m_tdata == 32'h7FC0_0000)
        else $error("non-canonical NaN on output");

    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind multi_peer_float_sum_reduce_unit mpfsr_checker u_mpfsr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
`default_nettype wire

/* sim/multi_peer_float_sum_reduce_unit_tb.sv */
// ----------------------------------------------------------------------------
// multi_peer_float_sum_reduce_unit_tb
// Streams peer element values through the reducer over a range of register
// settings and checks each sum against a bit-exact software adder chain.
// ----------------------------------------------------------------------------
module multi_peer_float_sum_reduce_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mpfsr_pkg::*;

    localparam int NPEER      = 8;
    localparam int DRAIN_WAIT = 30;
    localparam int CYCLE_MAX  = 400000;

    typedef struct {
        logic [31:0] val [NPEER];
        logic        tail;
    } element_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [NPEER*32-1:0]   s_tdata;   // peer_value_0 .. peer_value_7
    logic [0:0]            s_tuser;   // tail_mode
    logic                  m_tvalid;
    logic                  m_tready;
    logic [31:0]           m_tdata;   // sum_value
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [3:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    multi_peer_float_sum_reduce_unit #(.MAX_PEERS(NPEER)) i_dut (.*);

    element_t    pending_q [$];
    logic [31:0] sum_exp_q [$];
    element_t    drv_item;
    logic [3:0]  cfg_count;
    logic [2:0]  cfg_first;
    logic [1:0]  cfg_fmt;
    logic        src_hold;
    logic        quiet;
    int          stall_reqs;
    int          stall_served;
    int          stall_left;
    int          mismatches;
    int          cycles;

    // ---------------- float helpers ----------------

    function automatic logic [31:0] add_fp32(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] t;
        logic        sa, sb, sr;
        int          ea, eb, d, e;
        logic [27:0] ma, mb, s, sh;
        logic [24:0] mant;
        logic [2:0]  grs;
        if ((a[30:23] == 8'hFF && a[22:0] != 0) || (b[30:23] == 8'hFF && b[22:0] != 0))
            return QNAN32;
        if (a[30:23] == 8'hFF && b[30:23] == 8'hFF)
            return (a[31] == b[31]) ? a : QNAN32;
        if (a[30:23] == 8'hFF) return a;
        if (b[30:23] == 8'hFF) return b;
        // order by magnitude so the larger sits in a
        if (b[30:0] > a[30:0]) begin
            t = a; a = b; b = t;
        end
        sa = a[31]; sb = b[31];
        ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
        eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
        ma = {1'b0, (a[30:23] != 0), a[22:0], 3'b000};
        mb = {1'b0, (b[30:23] != 0), b[22:0], 3'b000};
        d  = ea - eb;
        if (d >= 28) begin
            mb = {27'd0, (mb != 0)};
        end else if (d > 0) begin
            sh = mb & ((28'd1 << d) - 28'd1);
            mb = (mb >> d) | {27'd0, (sh != 0)};
        end
        s  = (sa == sb) ? ma + mb : ma - mb;
        sr = sa;
        if (s == 0)
            return (sa == sb) ? {sa, 31'd0} : 32'd0;
        e = ea;
        if (s[27]) begin
            s = (s >> 1) | {27'd0, s[0]};
            e++;
        end else begin
            while (!s[26] && e > 1) begin
                s = s << 1;
                e--;
            end
        end
        mant = {1'b0, s[26:3]};
        grs  = s[2:0];
        if (grs > 3'd4 || (grs == 3'd4 && mant[0]))
            mant = mant + 25'd1;
        if (mant[24]) begin
            mant = mant >> 1;
            e++;
        end
        if (e >= 255)
            return {sr, 8'hFF, 23'd0};
        return {sr, mant[23] ? 8'(e) : 8'd0, mant[22:0]};
    endfunction

    function automatic logic [31:0] to_fp32(input logic [1:0] fmt, input logic [31:0] v);
        int         p;
        logic [9:0] man;
        logic [4:0] ex;
        logic [31:0] sm;
        man = v[9:0];
        ex  = v[14:10];
        p   = 0;
        if (fmt == FMT_BF16)
            return {v[15:0], 16'd0};
        if (fmt != FMT_FP16)
            return v;
        if (ex == 0) begin
            if (man == 0)
                return {v[15], 31'd0};
            for (int i = 0; i < 10; i++)
                if (man[i]) p = i;
            sm = 32'(man) << (23 - p);
            return {v[15], 8'(p + 103), sm[22:0]};
        end
        if (ex == 5'd31)
            return {v[15], 8'hFF, man, 13'd0};
        return {v[15], 8'(int'(ex) + 112), man, 13'd0};
    endfunction

    function automatic logic [31:0] from_fp32(input logic [1:0] fmt, input logic [31:0] x);
        logic        nan;
        logic [31:0] sgn, man, h, rem, half;
        int          e, sh;
        nan = (x[30:23] == 8'hFF) && (x[22:0] != 0);
        sgn = {16'd0, x[31], 15'd0};
        man = {9'd0, x[22:0]};
        e   = int'(x[30:23]) - 112;
        if (fmt == FMT_BF16)
            return nan ? QNANBF : 32'((33'(x) + 33'h7FFF + 33'(x[16])) >> 16);
        if (fmt != FMT_FP16)
            return nan ? QNAN32 : x;
        if (nan) return QNAN16;
        if (x[30:23] == 8'hFF || e >= 31) return sgn | 32'h7C00;
        if (e <= 0) begin
            if (e < -10) return sgn;
            man  = man | 32'h80_0000;
            sh   = 14 - e;
            h    = man >> sh;
            rem  = man & ((32'd1 << sh) - 1);
            half = 32'd1 << (sh - 1);
        end else begin
            h    = (32'(e) << 10) | (man >> 13);
            rem  = man & 32'h1FFF;
            half = 32'h1000;
        end
        if (rem > half || (rem == half && h[0]))
            h = h + 1;
        return sgn | h;
    endfunction

    function automatic logic [31:0] reduce_sum(input element_t it);
        int          n, start, p;
        logic [1:0]  fmt;
        logic [31:0] acc;
        n     = (cfg_count < 2) ? 2 : (cfg_count > NPEER) ? NPEER : int'(cfg_count);
        start = int'(cfg_first) % n;
        fmt   = (cfg_fmt == 2'd3) ? FMT_FP32 : cfg_fmt;
        if (it.tail) begin
            acc = to_fp32(fmt, it.val[start]);
            for (int k = 1; k < n; k++) begin
                p   = (start + k) % n;
                acc = add_fp32(acc, to_fp32(fmt, it.val[p]));
            end
            return from_fp32(fmt, acc);
        end
        acc = from_fp32(fmt, to_fp32(fmt, it.val[start]));
        for (int k = 1; k < n; k++) begin
            p   = (start + k) % n;
            acc = from_fp32(fmt, add_fp32(to_fp32(fmt, acc), to_fp32(fmt, it.val[p])));
        end
        return acc;
    endfunction

    // biased towards specials and comparable magnitudes
    function automatic logic [31:0] rand_elem(input logic [1:0] fmt);
        logic [31:0] r;
        logic [15:0] h;
        logic        sg;
        r  = $urandom;
        sg = r[31];
        if (fmt == FMT_FP16 || fmt == FMT_BF16) begin
            case ($urandom_range(9))
                0: h = {sg, 15'd0};
                1: h = (fmt == FMT_FP16) ? {sg, 15'h7C00} : {sg, 15'h7F80};
                2: h = (fmt == FMT_FP16) ? {sg, 5'h1F, 10'($urandom_range(1, 1023))}
                                         : {sg, 8'hFF, 7'($urandom_range(1, 127))};
                3: h = (fmt == FMT_FP16) ? {sg, 5'd0, r[9:0]} : {sg, 8'd0, r[6:0]};
                4: h = (fmt == FMT_FP16) ? {sg, 15'h7BFF} : {sg, 15'h7F7F};
                5, 6: h = (fmt == FMT_FP16) ? {sg, 5'($urandom_range(10, 20)), r[9:0]}
                                            : {sg, 8'($urandom_range(120, 135)), r[6:0]};
                default: h = r[15:0];
            endcase
            return {16'($urandom), h};
        end
        case ($urandom_range(9))
            0: return {sg, 31'd0};
            1: return {sg, 31'h7F80_0000};
            2: return {sg, 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
            3: return {sg, 8'd0, r[22:0]};
            4: return {sg, 31'h7F7F_FFFF};
            5, 6: return {sg, 8'($urandom_range(120, 135)), r[22:0]};
            default: return r;
        endcase
    endfunction

    // ---------------- clock, driver, monitor ----------------

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                sum_exp_q.push_back(reduce_sum(drv_item));
                void'(pending_q.pop_front());
            end
            if (s_tvalid && !s_tready) begin
                // hold the offered transaction
            end else if (pending_q.size() > 0 && !src_hold &&
                         (quiet || $urandom_range(99) >= 6)) begin
                drv_item = pending_q[0];
                for (int i = 0; i < NPEER; i++)
                    s_tdata[i*32 +: 32] <= drv_item.val[i];
                s_tuser  <= drv_item.tail;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted in cycles
    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_left <= 0;
        end else if (stall_served < stall_reqs) begin
            stall_served <= stall_served + 1;
            stall_left   <= 300;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge aclk) begin
        logic [31:0] want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (sum_exp_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: sum_value %h", m_tdata);
                end else begin
                    want = sum_exp_q.pop_front();
                    if (m_tdata !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("sum_value mismatch: expected %h actual %h",
                                     want, m_tdata);
                    end
                end
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= quiet || ($urandom_range(99) >= 6);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_MAX) begin
            $display("** multi_peer_float_sum_reduce_unit: FAILED **");
            $finish;
        end
    end

    // ---------------- sequencing ----------------

    task automatic reg_write(input mpfsr_reg_t idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(4 * int'(idx));
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_PEER_COUNT: cfg_count = value[3:0];
            REG_FIRST_PEER: cfg_first = value[2:0];
            default:        cfg_fmt   = value[1:0];
        endcase
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || s_tvalid || sum_exp_q.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic push_elem(input logic [31:0] v, input logic [31:0] w, input logic tail);
        element_t it;
        for (int i = 0; i < NPEER; i++)
            it.val[i] = (i % 2 == 0) ? v : w;
        it.tail = tail;
        pending_q.push_back(it);
    endtask

    task automatic push_random(input int count);
        element_t it;
        for (int j = 0; j < count; j++) begin
            for (int i = 0; i < NPEER; i++)
                it.val[i] = rand_elem(cfg_fmt);
            it.tail = 1'($urandom);
            pending_q.push_back(it);
        end
    endtask

    initial begin
        int counts [9] = '{2, 8, 4, 3, 0, 15, 8, 1, 8};
        int firsts [9] = '{0, 7, 1, 5, 0, 3, 0, 6, 4};
        int fmts   [9] = '{0, 1, 2, 3, 1, 2, 0, 1, 2};
        aresetn  = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        s_tvalid = 1'b0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cfg_count = 4'd2;
        cfg_first = 3'd0;
        cfg_fmt   = FMT_FP32;
        src_hold = 1'b0;
        quiet    = 1'b0;
        stall_reqs = 0;
        stall_served = 0;
        mismatches = 0;
        cycles   = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings first: extremes, cancellation, overflow, NaN
        push_elem(32'h0000_0000, 32'h8000_0000, 1'b0);
        push_elem(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_elem(32'h7F80_0000, 32'hFF80_0000, 1'b0);
        push_elem(32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b0);
        push_elem(32'h0000_0001, 32'h0000_0001, 1'b1);
        push_elem(32'h3F80_0000, 32'hBF80_0000, 1'b1);
        push_elem(32'h0080_0000, 32'h8000_0001, 1'b0);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            reg_write(REG_PEER_COUNT, 32'(counts[ph]) | ($urandom & 32'hFFFF_FFF0));
            reg_write(REG_FIRST_PEER, 32'(firsts[ph]));
            reg_write(REG_ELEMENT_FORMAT, 32'(fmts[ph]));
            // 16-bit extremes with junk in the upper half
            push_elem(32'hABCD_7BFF, 32'h1234_7BFF, 1'b0);
            push_elem(32'hFFFF_7F7F, 32'h0000_FC00, 1'b1);
            push_elem(32'h5555_0001, 32'hAAAA_8001, 1'b0);
            quiet = (ph == 3);
            if (ph == 5) begin
                stall_reqs++;
                push_random(150);
            end else begin
                push_random(75);
            end
            drain();
        end

        quiet = 1'b0;
        drain();
        if (mismatches == 0 && sum_exp_q.size() == 0) begin
            $display("** multi_peer_float_sum_reduce_unit: PASSED **");
        end else begin
            $display("** multi_peer_float_sum_reduce_unit: FAILED **");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/mpfsr_pkg.sv
rtl/mpfsr_cell.sv
rtl/multi_peer_float_sum_reduce_unit.sv
rtl/mpfsr_checker.sv
sim/multi_peer_float_sum_reduce_unit_tb.sv
